// ===== src/tcp_flow_header_compress_lookup_macros.svh =====
// ----------------------------------------------------------------------------
// Flow header compression lookup: assertion macros
// Shared wrappers for the concurrent checks in the RTL, clocked on clock and
// held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef TCP_FLOW_HEADER_COMPRESS_LOOKUP_MACROS_SVH
`define TCP_FLOW_HEADER_COMPRESS_LOOKUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFHC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tfhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Flow header compression lookup: package
// Constants, request and result types and the decision codes shared by the
// front, the queue and the back of the lookup.
// ----------------------------------------------------------------------------
package tfhc_pkg;

   // Flow cache geometry.
   localparam int SLOT_COUNT   = 1024;
   localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
   localparam int HASH_BITS    = 10;
   // Conditional subtractions needed to bring a hash below SLOT_COUNT.
   localparam int REDUCE_STEPS = HASH_BITS - SLOT_BITS + 1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] THRESHOLD_RESET = 16'd85;
   localparam logic [15:0] HASH_FOLD       = 16'h8005;

   typedef enum logic [1:0] {
      DEC_PASS = 2'd0,
      DEC_MISS = 2'd1,
      DEC_HIT  = 2'd2
   } decision_type;

   typedef struct packed {
      logic        lookup_enable;
      logic [15:0] total_length;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
   } req_type;

   typedef struct packed {
      decision_type decision;
      logic [9:0]   slot_id;
      logic         seq_change;
      logic         ack_change;
   } rsp_type;

   // One flow cache entry.
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
   } entry_type;

   // A classified request as it travels from front to back.
   typedef struct packed {
      logic                 eligible;
      logic [SLOT_BITS-1:0] slot;
      entry_type            entry;
   } work_type;

endpackage

// ===== src/tfhc_front.sv =====
// ----------------------------------------------------------------------------
// Flow header compression lookup: front
// Holds the length threshold, accepts requests, decides eligibility and
// hashes the flow keys to a cache slot.
// ----------------------------------------------------------------------------
module tfhc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  tfhc_pkg::req_type   req_data,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                clearing,
   input  logic                q_full,
   output logic                q_push,
   output tfhc_pkg::work_type  q_data
);

   logic [15:0] threshold_ff;
   logic [15:0] threshold_in;
   logic [tfhc_pkg::HASH_BITS-1:0] hash;

   function automatic logic [tfhc_pkg::HASH_BITS-1:0] flow_hash(tfhc_pkg::req_type r);
      logic [15:0] t;
      t = r.src_addr[31:16] ^ r.src_addr[15:0] ^ tfhc_pkg::HASH_FOLD
        ^ r.dst_addr[31:16] ^ r.dst_addr[15:0];
      t = {t[14:0], 1'b0} ^ r.src_port;
      t = {1'b1, t[15:1]} ^ r.dst_port;
      return t[tfhc_pkg::HASH_BITS-1:0];
   endfunction

   // Remainder by the slot count through shifted conditional subtractions.
   function automatic logic [tfhc_pkg::SLOT_BITS-1:0] reduce_slot(
      logic [tfhc_pkg::HASH_BITS-1:0] h
   );
      logic [tfhc_pkg::HASH_BITS:0] v;
      logic [tfhc_pkg::HASH_BITS:0] step;
      v = {1'b0, h};
      for (int k = tfhc_pkg::REDUCE_STEPS - 1; k >= 0; k--) begin
         step = (tfhc_pkg::HASH_BITS + 1)'(tfhc_pkg::SLOT_COUNT << k);
         if (v >= step) begin
            v = v - step;
         end
      end
      return v[tfhc_pkg::SLOT_BITS-1:0];
   endfunction

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         threshold_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tfhc_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign full   = q_full || clearing;
   assign q_push = push && !full;
   assign hash   = flow_hash(req_data);

   always_comb begin
      q_data.eligible         = req_data.lookup_enable
                                && (req_data.total_length > threshold_ff);
      q_data.slot             = reduce_slot(hash);
      q_data.entry.src_addr   = req_data.src_addr;
      q_data.entry.dst_addr   = req_data.dst_addr;
      q_data.entry.src_port   = req_data.src_port;
      q_data.entry.dst_port   = req_data.dst_port;
      q_data.entry.seq_number = req_data.seq_number;
      q_data.entry.ack_number = req_data.ack_number;
   end

endmodule

// ===== src/tfhc_queue.sv =====
// ----------------------------------------------------------------------------
// Flow header compression lookup: work queue
// Short first-in first-out queue of classified requests between the front
// and the back.
// ----------------------------------------------------------------------------
`include "tcp_flow_header_compress_lookup_macros.svh"

module tfhc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tfhc_pkg::work_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output tfhc_pkg::work_type  pop_data
);

   tfhc_pkg::work_type entries_ff [tfhc_pkg::QUEUE_DEPTH];

   logic [tfhc_pkg::QUEUE_BITS-1:0] wr_ptr_ff;
   logic [tfhc_pkg::QUEUE_BITS-1:0] wr_ptr_in;
   logic [tfhc_pkg::QUEUE_BITS-1:0] rd_ptr_ff;
   logic [tfhc_pkg::QUEUE_BITS-1:0] rd_ptr_in;
   logic [tfhc_pkg::QUEUE_BITS:0]   count_ff;
   logic [tfhc_pkg::QUEUE_BITS:0]   count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full     = (count_ff == (tfhc_pkg::QUEUE_BITS + 1)'(tfhc_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TFHC_ASSERT_SAME(a_queue_count_bound, 1'b1, count_ff <= (tfhc_pkg::QUEUE_BITS + 1)'(tfhc_pkg::QUEUE_DEPTH), "work queue count above depth")
   `TFHC_ASSERT_NEXT(a_queue_count_grows, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "work queue count did not grow on push")
   `TFHC_ASSERT_NEXT(a_queue_count_falls, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "work queue count did not fall on pop")

endmodule

// ===== src/tfhc_back.sv =====
// ----------------------------------------------------------------------------
// Flow header compression lookup: back
// Clears the flow cache after reset, reads the selected slot, compares keys,
// installs new flows and holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "tcp_flow_header_compress_lookup_macros.svh"

module tfhc_back (
   input  logic                clock,
   input  logic                reset,
   output logic                clearing,
   input  logic                q_valid,
   input  tfhc_pkg::work_type  q_data,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output tfhc_pkg::rsp_type   rsp_data
);

   tfhc_pkg::entry_type cache_mem [tfhc_pkg::SLOT_COUNT];

   logic                           clear_active_ff;
   logic                           clear_active_in;
   logic [tfhc_pkg::SLOT_BITS-1:0] clear_addr_ff;
   logic [tfhc_pkg::SLOT_BITS-1:0] clear_addr_in;

   logic                           b_valid_ff;
   logic                           b_valid_in;
   tfhc_pkg::work_type             b_work_ff;
   tfhc_pkg::entry_type            rd_data_ff;
   logic                           fwd_valid_ff;
   logic                           fwd_valid_in;
   logic [tfhc_pkg::SLOT_BITS-1:0] fwd_slot_ff;
   tfhc_pkg::entry_type            fwd_data_ff;

   logic                           c_valid_ff;
   logic                           c_valid_in;
   tfhc_pkg::rsp_type              c_rsp_ff;
   tfhc_pkg::rsp_type              c_rsp_in;

   logic                           advance;
   logic                           b_fire;
   logic                           b_write;
   logic                           key_match;
   tfhc_pkg::entry_type            stored;
   logic                           wr_en;
   logic [tfhc_pkg::SLOT_BITS-1:0] wr_addr;
   tfhc_pkg::entry_type            wr_data;

   // Sweep of the cache after reset, one slot a cycle.
   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         if (clear_addr_ff == tfhc_pkg::SLOT_BITS'(tfhc_pkg::SLOT_COUNT - 1)) begin
            clear_active_in = 1'b0;
         end else begin
            clear_addr_in = clear_addr_ff + 1'b1;
         end
      end
   end

   assign clearing = clear_active_ff;

   assign b_fire  = b_valid_ff && (!c_valid_ff || pop);
   assign advance = !b_valid_ff || b_fire;
   assign q_pop   = advance && q_valid && !clear_active_ff;

   // A write made at the edge that issued this read is not yet in the read data.
   assign stored = (fwd_valid_ff && (fwd_slot_ff == b_work_ff.slot)) ? fwd_data_ff
                                                                     : rd_data_ff;

   assign key_match = (stored.src_addr == b_work_ff.entry.src_addr)
                   && (stored.dst_addr == b_work_ff.entry.dst_addr)
                   && (stored.src_port == b_work_ff.entry.src_port)
                   && (stored.dst_port == b_work_ff.entry.dst_port);

   assign b_write = b_fire && b_work_ff.eligible && !key_match;

   always_comb begin
      c_rsp_in.decision   = tfhc_pkg::DEC_PASS;
      c_rsp_in.slot_id    = '0;
      c_rsp_in.seq_change = 1'b0;
      c_rsp_in.ack_change = 1'b0;
      if (b_work_ff.eligible) begin
         c_rsp_in.slot_id = 10'(b_work_ff.slot);
         if (key_match) begin
            c_rsp_in.decision   = tfhc_pkg::DEC_HIT;
            c_rsp_in.seq_change = (stored.seq_number != b_work_ff.entry.seq_number);
            c_rsp_in.ack_change = (stored.ack_number != b_work_ff.entry.ack_number);
         end else begin
            c_rsp_in.decision = tfhc_pkg::DEC_MISS;
         end
      end
   end

   always_comb begin
      b_valid_in   = b_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (advance) begin
         b_valid_in   = q_pop;
         fwd_valid_in = b_write;
      end
      c_valid_in = c_valid_ff;
      if (b_fire) begin
         c_valid_in = 1'b1;
      end else if (pop) begin
         c_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         b_valid_ff      <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         c_valid_ff      <= 1'b0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
         b_valid_ff      <= b_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         c_valid_ff      <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_work_ff   <= q_data;
         fwd_slot_ff <= b_work_ff.slot;
         fwd_data_ff <= b_work_ff.entry;
      end
      if (b_fire) begin
         c_rsp_ff <= c_rsp_in;
      end
   end

   assign wr_en   = clear_active_ff || b_write;
   assign wr_addr = clear_active_ff ? clear_addr_ff : b_work_ff.slot;
   assign wr_data = clear_active_ff ? '0 : b_work_ff.entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cache_mem[wr_addr] <= wr_data;
      end
      if (advance) begin
         rd_data_ff <= cache_mem[q_data.slot];
      end
   end

   assign empty    = !c_valid_ff;
   assign rsp_data = c_rsp_ff;

   `TFHC_ASSERT_SAME(a_back_idle_while_clearing, clear_active_ff, !b_valid_ff && !c_valid_ff, "request in flight during cache clear")
   `TFHC_ASSERT_NEXT(a_back_forward_after_write, b_write, fwd_valid_ff && (fwd_slot_ff == $past(b_work_ff.slot)), "install not forwarded")
   `TFHC_ASSERT_SAME(a_back_pass_is_zero, c_valid_ff && (c_rsp_ff.decision == tfhc_pkg::DEC_PASS), (c_rsp_ff.slot_id == '0) && !c_rsp_ff.seq_change && !c_rsp_ff.ack_change, "ineligible result not cleared")
   `TFHC_ASSERT_SAME(a_back_miss_no_change, c_valid_ff && (c_rsp_ff.decision == tfhc_pkg::DEC_MISS), !c_rsp_ff.seq_change && !c_rsp_ff.ack_change, "miss result reports a change")

endmodule

// ===== src/tcp_flow_header_compress_lookup.sv =====
// ----------------------------------------------------------------------------
// TCP/IP header compression flow cache lookup
// Top level: front classifier, work queue and cache back end.
// ----------------------------------------------------------------------------
// Each request carries one packet's IPv4 and TCP header fields and produces
// exactly one result, in request order. A packet is looked up only when
// its lookup enable flag is set and total_length is strictly above the
// programmable length threshold (reset value 85); otherwise the result is
// decision 0 with all other fields zero. Looked-up packets hash their
// addresses and ports to a cache slot: on a key mismatch the slot is
// overwritten with the packet's keys, sequence and acknowledgement numbers
// (decision 1); on a match the slot is left alone and the result is decision
// 2 with the sequence and acknowledgement change flags. After reset the block
// clears all 1024 cache slots, one per cycle, and holds full high while it
// does so; threshold writes are taken at any time. Once running, the
// block takes one request per cycle for as long as results are popped as
// fast; the slot read and compare is a read-modify-write over one read and
// one write port with a one-deep forwarding path, so back-to-back requests to
// the same slot see each other's installs. A result moves from the work
// queue into the registered cache read and from there into the result
// register, which drives the result ports.
// The four-entry work queue lets the front keep accepting while a result
// waits to be popped.
// ----------------------------------------------------------------------------
module tcp_flow_header_compress_lookup (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  tfhc_pkg::req_type   req_data,
   output logic                empty,
   input  logic                pop,
   output tfhc_pkg::rsp_type   rsp_data,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data
);

   logic               clearing;
   logic               q_push;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   tfhc_pkg::work_type q_push_data;
   tfhc_pkg::work_type q_pop_data;

   // The front classifies and hashes in the cycle the request is accepted.
   tfhc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .clearing         (clearing),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   // The queue decouples request acceptance from back-end stalls.
   tfhc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   // The back owns the flow cache and the result register.
   tfhc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .q_valid  (q_valid),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sv/tcp_flow_header_compress_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// Flow header compression lookup: self-checking testbench
// Drives packet header requests through the queue-style request port, keeps a
// shadow copy of the flow cache and length threshold, and compares every
// popped result against the value predicted when its request was accepted.
// ----------------------------------------------------------------------------
module tcp_flow_header_compress_lookup_tb;

   localparam int FLOW_POOL = 16;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   tfhc_pkg::req_type req_data;
   logic              empty;
   logic              pop;
   tfhc_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic [15:0]       csr_write_data;

   // Shadow of the block's state: the flow cache and the threshold register.
   tfhc_pkg::entry_type flow_table [tfhc_pkg::SLOT_COUNT];
   logic [15:0]         length_limit;

   // Requests waiting to be driven and results waiting to be popped.
   tfhc_pkg::req_type pending_requests [$];
   tfhc_pkg::rsp_type expected_results [$];

   // Flows that the random stimulus returns to, so that hits and changes in
   // the sequence and acknowledgement numbers are common.
   tfhc_pkg::req_type flow_pool [FLOW_POOL];

   int mismatch_count;
   int burst_left;
   int gap_left;
   logic [7:0] stall_pattern;
   logic [5:0] stall_phase;

   tcp_flow_header_compress_lookup DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data         (req_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A hung block must still end the run. The bound allows for the cache
   // clearing pass after reset and for every request meeting both the
   // longest sender gap and the longest receiver stall, many times over.
   initial begin
      #3200000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Slot selection: fold the addresses into 16 bits with the fixed constant,
   // shift in the source port from the left and the destination port after a
   // right shift that sets the top bit, then keep the low ten bits.
   function automatic int flow_slot(input tfhc_pkg::req_type r);
      logic [15:0] h;
      h = r.src_addr[31:16] ^ r.src_addr[15:0] ^ tfhc_pkg::HASH_FOLD
          ^ r.dst_addr[31:16] ^ r.dst_addr[15:0];
      h = {h[14:0], 1'b0} ^ r.src_port;
      h = {1'b1, h[15:1]} ^ r.dst_port;
      return int'(h[9:0]) % tfhc_pkg::SLOT_COUNT;
   endfunction

   // Works out the result of one accepted request and applies any install to
   // the shadow cache. A hit leaves the slot exactly as it was.
   function automatic tfhc_pkg::rsp_type predict_lookup(input tfhc_pkg::req_type r);
      tfhc_pkg::rsp_type   res;
      int                  slot;
      tfhc_pkg::entry_type stored;
      res = '0;
      if (!r.lookup_enable || r.total_length <= length_limit) begin
         return res;
      end
      slot        = flow_slot(r);
      stored      = flow_table[slot];
      res.slot_id = 10'(slot);
      if (stored.src_addr == r.src_addr && stored.dst_addr == r.dst_addr &&
          stored.src_port == r.src_port && stored.dst_port == r.dst_port) begin
         res.decision   = tfhc_pkg::DEC_HIT;
         res.seq_change = (stored.seq_number != r.seq_number);
         res.ack_change = (stored.ack_number != r.ack_number);
      end else begin
         res.decision     = tfhc_pkg::DEC_MISS;
         flow_table[slot] = '{r.src_addr, r.dst_addr, r.src_port, r.dst_port,
                              r.seq_number, r.ack_number};
      end
      return res;
   endfunction

   function automatic tfhc_pkg::req_type make_req(input logic valid, input logic [15:0] len,
                                        input logic [31:0] sa, input logic [31:0] da,
                                        input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [31:0] seq, input logic [31:0] ack);
      tfhc_pkg::req_type r;
      r = '{valid, len, sa, da, sp, dp, seq, ack};
      return r;
   endfunction

   // Replaces one pooled flow, either with a fresh random one or with a twin
   // of its neighbour whose destination address has its halves swapped. The
   // twin hashes to the same slot with different keys, so the two evict each
   // other.
   function automatic void refresh_flow(input int k);
      tfhc_pkg::req_type f;
      if (k > 0 && $urandom_range(0, 3) == 0) begin
         f          = flow_pool[k-1];
         f.dst_addr = {f.dst_addr[15:0], f.dst_addr[31:16]};
      end else begin
         f.lookup_enable = 1'b1;
         f.total_length  = 16'hFFFF;
         f.src_addr      = $urandom;
         f.dst_addr      = $urandom;
         f.src_port      = 16'($urandom);
         f.dst_port      = 16'($urandom);
         f.seq_number    = $urandom;
         f.ack_number    = $urandom;
      end
      flow_pool[k] = f;
   endfunction

   // Lengths cluster around the threshold, with both ends of the field and a
   // good share of plainly eligible packets.
   function automatic logic [15:0] pick_length();
      int lim;
      lim = int'(length_limit);
      case ($urandom_range(0, 7))
         0: return length_limit;
         1: return length_limit + 16'd1;
         2: return length_limit - 16'd1;
         3: return 16'hFFFF;
         4: return 16'd0;
         default: begin
            if (lim == 16'hFFFF) begin
               return 16'($urandom);
            end
            return 16'(lim + 1 + $urandom_range(0, 65534 - lim));
         end
      endcase
   endfunction

   // Most requests revisit a pooled flow, with the sequence and
   // acknowledgement numbers either held or advanced; the rest are noise with
   // every field random.
   function automatic tfhc_pkg::req_type random_request();
      tfhc_pkg::req_type r;
      int                k;
      if ($urandom_range(0, 99) < 12) begin
         r.lookup_enable = 1'($urandom);
         r.total_length  = 16'($urandom);
         r.src_addr      = $urandom;
         r.dst_addr      = $urandom;
         r.src_port      = 16'($urandom);
         r.dst_port      = 16'($urandom);
         r.seq_number    = $urandom;
         r.ack_number    = $urandom;
         return r;
      end
      k = $urandom_range(0, FLOW_POOL - 1);
      if ($urandom_range(0, 19) == 0) begin
         refresh_flow(k);
      end
      case ($urandom_range(0, 3))
         0: flow_pool[k].seq_number += $urandom_range(1, 1460);
         1: flow_pool[k].ack_number += $urandom_range(1, 1460);
         default: ;
      endcase
      r               = flow_pool[k];
      r.lookup_enable = ($urandom_range(0, 15) != 0);
      r.total_length  = pick_length();
      return r;
   endfunction

   // Holds the stimulus back until every request has been driven and every
   // expected result popped, then allows for the block's pipeline to settle.
   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || push || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Threshold writes are made only while the block is idle, so the shadow
   // copy can change at the same moment without any request straddling it.
   task automatic write_threshold(input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_limit = value;
   endtask

   task automatic run_phase(input logic [15:0] threshold, input int count);
      wait_until_drained();
      write_threshold(threshold);
      repeat (count) pending_requests.push_back(random_request());
   endtask

   // Request driver. A request is accepted at an edge where push is high and
   // full is low; the prediction is made at that same edge. The sender works
   // in bursts of random length separated by random gaps, some of them zero.
   always @(posedge clock) begin : request_driver
      logic              send_next;
      tfhc_pkg::req_type next_req;
      send_next = 1'b0;
      next_req  = req_data;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (push) begin
            expected_results.push_back(predict_lookup(req_data));
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_requests.size() != 0) begin
            next_req  = pending_requests.pop_front();
            send_next = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 23);
               case ($urandom_range(0, 3))
                  0, 1: gap_left = 0;
                  2: gap_left = $urandom_range(1, 3);
                  default: gap_left = $urandom_range(4, 12);
               endcase
            end
         end
         push     <= send_next;
         req_data <= next_req;
      end
   end

   // Result monitor. The receiver stalls on a rotating eight-bit pattern that
   // is reloaded each time the six-bit phase counter wraps; a third of the
   // reloads pop on every cycle, and every other pattern has at least one pop slot in it.
   always @(posedge clock) begin : result_monitor
      tfhc_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding: %p",
                                         rsp_data));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.decision !== want.decision)
                  report_mismatch($sformatf("decision %0d, expected %0d",
                                            rsp_data.decision, want.decision));
               if (rsp_data.slot_id !== want.slot_id)
                  report_mismatch($sformatf("slot_id %0d, expected %0d",
                                            rsp_data.slot_id, want.slot_id));
               if (rsp_data.seq_change !== want.seq_change)
                  report_mismatch($sformatf("seq_change %0b, expected %0b",
                                            rsp_data.seq_change, want.seq_change));
               if (rsp_data.ack_change !== want.ack_change)
                  report_mismatch($sformatf("ack_change %0b, expected %0b",
                                            rsp_data.ack_change, want.ack_change));
            end
         end
         stall_phase++;
         if (stall_phase == 6'd0) begin
            if ($urandom_range(0, 2) == 0) begin
               stall_pattern = 8'hFF;
            end else begin
               stall_pattern = 8'($urandom) | (8'd1 << $urandom_range(0, 7));
            end
         end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
         end
         pop <= stall_pattern[0];
      end
   end

   initial begin
      // Every input is known from time zero; reset is held high at the start.
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      mismatch_count   = 0;
      burst_left       = 0;
      gap_left         = 0;
      stall_pattern    = 8'hFF;
      stall_phase      = '0;
      length_limit     = tfhc_pkg::THRESHOLD_RESET;
      for (int i = 0; i < tfhc_pkg::SLOT_COUNT; i++) flow_table[i] = '0;
      for (int k = 0; k < FLOW_POOL; k++) refresh_flow(k);
      flow_pool[0] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset threshold. The all-zero flow
      // matches a cleared slot and so hits against stored numbers of zero.
      pending_requests.push_back(make_req(1'b1, 16'd86, '0, '0, '0, '0, '0, '0));
      pending_requests.push_back(make_req(1'b1, 16'd86, '0, '0, '0, '0, '1, '0));
      pending_requests.push_back(make_req(1'b1, 16'd86, '0, '0, '0, '0, '0, '1));
      // A length equal to the threshold is not eligible, nor is any request
      // with the lookup enable flag clear.
      pending_requests.push_back(make_req(1'b1, 16'd85, 32'hC0A80001, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd100, 32'd200));
      pending_requests.push_back(make_req(1'b0, 16'hFFFF, 32'hC0A80001, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd100, 32'd200));
      // Install a flow, hit it unchanged, then hit it with both numbers moved.
      pending_requests.push_back(make_req(1'b1, 16'd86, 32'hC0A80001, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd100, 32'd200));
      pending_requests.push_back(make_req(1'b1, 16'd86, 32'hC0A80001, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd100, 32'd200));
      pending_requests.push_back(make_req(1'b1, 16'd1500, 32'hC0A80001, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd1560, 32'd260));
      // Swapping the halves of the source address keeps the slot but changes
      // the key, so the two flows evict each other in turn.
      pending_requests.push_back(make_req(1'b1, 16'd1500, 32'h0001C0A8, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd7, 32'd9));
      pending_requests.push_back(make_req(1'b1, 16'd1500, 32'hC0A80001, 32'h0A000002,
                                          16'h1F90, 16'hC350, 32'd1560, 32'd260));
      // Every field at its top value, then the same flow with zero numbers.
      pending_requests.push_back(make_req(1'b1, 16'hFFFF, '1, '1, '1, '1, '1, '1));
      pending_requests.push_back(make_req(1'b1, 16'hFFFF, '1, '1, '1, '1, '1, '1));
      pending_requests.push_back(make_req(1'b1, 16'hFFFF, '1, '1, '1, '1, '0, '0));
      pending_requests.push_back(make_req(1'b1, 16'd0, '1, '1, '1, '1, '1, '1));
      repeat (300) pending_requests.push_back(random_request());

      // Threshold settings, the extremes among them. Each phase starts only
      // once the block has drained, which is also where the sender pauses
      // until every expected result has come back.
      run_phase(16'd0, 400);
      run_phase(16'hFFFF, 100);
      run_phase(16'hFFFE, 100);
      run_phase(16'($urandom_range(1, 65533)), 400);
      run_phase(16'($urandom_range(40, 1500)), 400);
      run_phase(tfhc_pkg::THRESHOLD_RESET, 200);

      wait_until_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
